>>> design/per_flow_token_bucket_limiter_macros.svh
// assertion macros for the per-flow token bucket limiter checker
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef PER_FLOW_TOKEN_BUCKET_LIMITER_MACROS_SVH
`define PER_FLOW_TOKEN_BUCKET_LIMITER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PFTBL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pftbl check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define PFTBL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pftbl check failed");

`endif

>>> design/pftbl_pkg.sv
// shared types and constants for the per-flow token bucket limiter
// used by pftbl_ctrl, pftbl_dpath, the top level and the checker
`default_nettype none

package pftbl_pkg;

  localparam int FLOW_COUNT_DEF = 256;
  localparam int FLOW_ID_W      = 8;
  localparam int FLOW_IDS       = 256;
  localparam int SLOT_MAX       = 256;

  localparam int TOKEN_W = 16;
  localparam int TIME_W  = 32;
  localparam int RATE_W  = 20;
  localparam int CFG_W   = 20;
  localparam int ENTRY_W = TOKEN_W + TIME_W;

  localparam logic [TOKEN_W-1:0] BURST_RESET = 16'd60;
  localparam logic [RATE_W-1:0]  RATE_RESET  = 20'd60;
  localparam logic [TIME_W-1:0]  SECONDS_PER_MINUTE = 32'd60;

  // elapsed * rate product, and the divide by 60 done as a reciprocal multiply
  localparam int PROD_W      = TIME_W + RATE_W;
  localparam int QUOT_W      = TOKEN_W + 1;
  localparam int SAT_W       = 22;
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_PW    = SAT_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_MULT   = 23'd4473925;
  localparam logic [PROD_W-1:0]  SAT_PRODUCT  = 52'd3932160;
  localparam logic [QUOT_W-1:0]  QUOT_SAT     = 17'h10000;

  localparam logic KIND_CHECK = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  localparam logic CFG_IDX_BURST  = 1'b0;
  localparam logic CFG_IDX_REFILL = 1'b1;

  localparam logic [1:0] STATUS_ALLOWED    = 2'd0;
  localparam logic [1:0] STATUS_EXCEEDED   = 2'd1;
  localparam logic [1:0] STATUS_RESET_DONE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_DIV,
    S_UPD
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic mem_read;
    logic mul;
    logic div;
    logic commit;
  } pftbl_cmd_t;

  typedef struct packed {
    logic out_free;
  } pftbl_stat_t;

endpackage

`default_nettype wire

>>> design/per_flow_token_bucket_limiter.sv
// Per-flow token bucket limiter. Each flow keeps a token count and a refill
// stamp in an on-chip memory; a check item refills the bucket by
// elapsed * refill_per_minute / 60 (capped at the burst limit), takes one token
// if there is one and reports the outcome, a reset item forgets the flow. One
// item is worked on at a time: after acceptance the input stalls while the
// item goes through a memory read, the elapsed-times-rate multiply, the
// divide by 60 (reciprocal multiply) and the update/write-back; the input
// is free again once the update step has written the result register. A
// finished result sits in an output register, so the next item is accepted
// while it waits; the update step holds only if a second result would
// overwrite one not yet taken. No clearing pass is needed after reset:
// per-slot valid bits start clear. flow_id is reduced modulo FLOW_COUNT;
// configuration writes take effect at once, also on an item in flight.
// Depends on pftbl_pkg, pftbl_ctrl and pftbl_dpath.
`default_nettype none

module per_flow_token_bucket_limiter #(
  parameter int FLOW_COUNT = pftbl_pkg::FLOW_COUNT_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire                                  cfg_idx_i,
  input  wire  [pftbl_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire                                  kind_i,
  input  wire  [pftbl_pkg::FLOW_ID_W-1:0]      flow_id_i,
  input  wire  [pftbl_pkg::TIME_W-1:0]         now_seconds_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic [1:0]                           status_o,
  output logic [pftbl_pkg::TOKEN_W-1:0]        remaining_o,
  output logic [pftbl_pkg::TOKEN_W-1:0]        limit_o,
  output logic [pftbl_pkg::TIME_W-1:0]         window_end_o,
  output logic [pftbl_pkg::TIME_W-1:0]         retry_wait_o
);

  pftbl_pkg::pftbl_cmd_t  cmd;
  pftbl_pkg::pftbl_stat_t stat;

  pftbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pftbl_dpath #(
    .FLOW_COUNT (FLOW_COUNT)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .kind_i        (kind_i),
    .flow_id_i     (flow_id_i),
    .now_seconds_i (now_seconds_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .remaining_o   (remaining_o),
    .limit_o       (limit_o),
    .window_end_o  (window_end_o),
    .retry_wait_o  (retry_wait_o),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

`default_nettype wire

>>> design/pftbl_ctrl.sv
// sequencer for the token bucket limiter: one item at a time
// through read, multiply, divide and update steps; uses pftbl_pkg
`default_nettype none

module pftbl_ctrl (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire pftbl_pkg::pftbl_stat_t stat_i,
  output pftbl_pkg::pftbl_cmd_t    cmd_o
);

  pftbl_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pftbl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      pftbl_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = pftbl_pkg::S_READ;
        end
      end
      pftbl_pkg::S_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = pftbl_pkg::S_MUL;
      end
      pftbl_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = pftbl_pkg::S_DIV;
      end
      pftbl_pkg::S_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = pftbl_pkg::S_UPD;
      end
      pftbl_pkg::S_UPD: begin
        // hold here while the previous result is still waiting
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = pftbl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pftbl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/pftbl_dpath.sv
// datapath of the token bucket limiter: config registers, bucket memory,
// valid bits, refill arithmetic and the result register; uses pftbl_pkg
`default_nettype none

module pftbl_dpath #(
  parameter int FLOW_COUNT = pftbl_pkg::FLOW_COUNT_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire                                  cfg_idx_i,
  input  wire  [pftbl_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  wire                                  kind_i,
  input  wire  [pftbl_pkg::FLOW_ID_W-1:0]      flow_id_i,
  input  wire  [pftbl_pkg::TIME_W-1:0]         now_seconds_i,
  input  wire                                  out_stall_i,
  output logic                                 out_valid_o,
  output logic [1:0]                           status_o,
  output logic [pftbl_pkg::TOKEN_W-1:0]        remaining_o,
  output logic [pftbl_pkg::TOKEN_W-1:0]        limit_o,
  output logic [pftbl_pkg::TIME_W-1:0]         window_end_o,
  output logic [pftbl_pkg::TIME_W-1:0]         retry_wait_o,
  input  wire pftbl_pkg::pftbl_cmd_t           cmd_i,
  output pftbl_pkg::pftbl_stat_t               stat_o
);

  // only the first 256 slots can ever be addressed by an 8-bit flow id
  localparam int SLOT_COUNT = (FLOW_COUNT < pftbl_pkg::SLOT_MAX) ? FLOW_COUNT
                                                                 : pftbl_pkg::SLOT_MAX;
  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int TOKEN_W = pftbl_pkg::TOKEN_W;
  localparam int TIME_W  = pftbl_pkg::TIME_W;

  // flow id to slot, reduced modulo FLOW_COUNT at elaboration
  logic [SLOT_W-1:0] slot_lut [pftbl_pkg::FLOW_IDS];
  for (genvar gv = 0; gv < pftbl_pkg::FLOW_IDS; gv++) begin : g_slot
    assign slot_lut[gv] = SLOT_W'(gv % FLOW_COUNT);
  end

  // configuration
  logic [TOKEN_W-1:0]            burst_q;
  logic [pftbl_pkg::RATE_W-1:0]  rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q <= pftbl_pkg::BURST_RESET;
      rate_q  <= pftbl_pkg::RATE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pftbl_pkg::CFG_IDX_BURST:  burst_q <= cfg_wdata_i[TOKEN_W-1:0];
        pftbl_pkg::CFG_IDX_REFILL: rate_q  <= cfg_wdata_i[pftbl_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic               kind_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [TIME_W-1:0]  now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      slot_q <= slot_lut[flow_id_i];
      now_q  <= now_seconds_i;
    end
  end

  // bucket memory: {tokens, stamp}
  logic [pftbl_pkg::ENTRY_W-1:0] bucket_mem [SLOT_COUNT];
  logic [pftbl_pkg::ENTRY_W-1:0] rd_data_q;
  logic [pftbl_pkg::ENTRY_W-1:0] wr_data;
  logic                          mem_we;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bucket_mem[slot_q] <= wr_data;
    end
    if (cmd_i.mem_read) begin
      rd_data_q <= bucket_mem[slot_q];
    end
  end

  logic [TOKEN_W-1:0] tok_rd;
  logic [TIME_W-1:0]  stamp_rd;
  assign tok_rd   = rd_data_q[pftbl_pkg::ENTRY_W-1:TIME_W];
  assign stamp_rd = rd_data_q[TIME_W-1:0];

  // valid bits
  logic [SLOT_COUNT-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.commit) begin
      valid_q[slot_q] <= (kind_q == pftbl_pkg::KIND_CHECK);
    end
  end

  // multiply step: elapsed time times rate
  logic [TIME_W-1:0]               elapsed;
  logic                            hit_d, hit_q;
  logic                            adv_d, adv_q;
  logic [pftbl_pkg::PROD_W-1:0]    prod_d, prod_q;

  always_comb begin
    elapsed = now_q - stamp_rd;
    hit_d   = valid_q[slot_q];
    // time moved forward by 1 .. 2^31-1 seconds
    adv_d   = hit_d && (elapsed != '0) && !elapsed[TIME_W-1];
    prod_d  = pftbl_pkg::PROD_W'(elapsed) * pftbl_pkg::PROD_W'(rate_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      hit_q  <= hit_d;
      adv_q  <= adv_d;
      prod_q <= prod_d;
    end
  end

  // divide step: product / 60, saturated above any possible burst size
  logic [pftbl_pkg::RECIP_PW-1:0] recip;
  logic [pftbl_pkg::QUOT_W-1:0]   quot_d, quot_q;

  always_comb begin
    recip = pftbl_pkg::RECIP_PW'(prod_q[pftbl_pkg::SAT_W-1:0])
          * pftbl_pkg::RECIP_PW'(pftbl_pkg::RECIP_MULT);
    if (prod_q >= pftbl_pkg::SAT_PRODUCT) begin
      quot_d = pftbl_pkg::QUOT_SAT;
    end else begin
      quot_d = recip[pftbl_pkg::RECIP_PW-1:pftbl_pkg::RECIP_SHIFT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div) begin
      quot_q <= quot_d;
    end
  end

  // update step
  logic [TOKEN_W+1:0]  sum;
  logic [TOKEN_W-1:0]  tok_base;
  logic [TOKEN_W-1:0]  tok_new;
  logic [TIME_W-1:0]   stamp_new;
  logic [TIME_W-1:0]   window_end;
  logic [TIME_W-1:0]   retry;
  logic [1:0]          status_d;
  logic [TOKEN_W-1:0]  remaining_d;
  logic [TOKEN_W-1:0]  limit_d;
  logic [TIME_W-1:0]   window_end_d;
  logic [TIME_W-1:0]   retry_d;

  always_comb begin
    sum = (TOKEN_W + 2)'(tok_rd) + (TOKEN_W + 2)'(quot_q);
    if (!hit_q) begin
      tok_base  = burst_q;
      stamp_new = now_q;
    end else if (adv_q) begin
      tok_base  = (sum > (TOKEN_W + 2)'(burst_q)) ? burst_q : sum[TOKEN_W-1:0];
      stamp_new = now_q;
    end else begin
      tok_base  = tok_rd;
      stamp_new = stamp_rd;
    end

    if (tok_base != '0) begin
      tok_new  = tok_base - TOKEN_W'(1);
      status_d = pftbl_pkg::STATUS_ALLOWED;
    end else begin
      tok_new  = tok_base;
      status_d = pftbl_pkg::STATUS_EXCEEDED;
    end

    window_end = stamp_new + pftbl_pkg::SECONDS_PER_MINUTE;
    retry      = window_end - now_q;
    if (retry[TIME_W-1]) begin
      retry = '0;
    end

    wr_data = {tok_new, stamp_new};
    mem_we  = cmd_i.commit && (kind_q == pftbl_pkg::KIND_CHECK);

    if (kind_q == pftbl_pkg::KIND_RESET) begin
      status_d     = pftbl_pkg::STATUS_RESET_DONE;
      remaining_d  = '0;
      limit_d      = '0;
      window_end_d = '0;
      retry_d      = '0;
    end else begin
      remaining_d  = tok_new;
      limit_d      = burst_q;
      window_end_d = window_end;
      retry_d      = retry;
    end
  end

  // result register
  logic                out_valid_q;
  logic [1:0]          status_q;
  logic [TOKEN_W-1:0]  remaining_q;
  logic [TOKEN_W-1:0]  limit_q;
  logic [TIME_W-1:0]   window_end_q;
  logic [TIME_W-1:0]   retry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q     <= status_d;
      remaining_q  <= remaining_d;
      limit_q      <= limit_d;
      window_end_q <= window_end_d;
      retry_q      <= retry_d;
    end
  end

  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign remaining_o   = remaining_q;
  assign limit_o       = limit_q;
  assign window_end_o  = window_end_q;
  assign retry_wait_o  = retry_q;

endmodule

`default_nettype wire

>>> design/pftbl_chk.sv
// port-level checker for the token bucket limiter, bound to the top level
// uses pftbl_pkg and the macros in per_flow_token_bucket_limiter_macros.svh
`default_nettype none

`include "per_flow_token_bucket_limiter_macros.svh"

module pftbl_chk (
  input wire                                  clk_i,
  input wire                                  rst_ni,
  input wire                                  out_valid_o,
  input wire                                  out_stall_i,
  input wire [1:0]                            status_o,
  input wire [pftbl_pkg::TOKEN_W-1:0]         remaining_o,
  input wire [pftbl_pkg::TOKEN_W-1:0]         limit_o,
  input wire [pftbl_pkg::TIME_W-1:0]          window_end_o,
  input wire [pftbl_pkg::TIME_W-1:0]          retry_wait_o
);

  localparam int PAYLOAD_W = 2 + 2 * pftbl_pkg::TOKEN_W + 2 * pftbl_pkg::TIME_W;

  logic                 status_known;
  logic                 is_reset;
  logic                 is_refused;
  logic                 fields_zero;
  logic [PAYLOAD_W-1:0] out_payload;

  assign status_known = (status_o == pftbl_pkg::STATUS_ALLOWED)
                     || (status_o == pftbl_pkg::STATUS_EXCEEDED)
                     || (status_o == pftbl_pkg::STATUS_RESET_DONE);
  assign is_reset     = out_valid_o && (status_o == pftbl_pkg::STATUS_RESET_DONE);
  assign is_refused   = out_valid_o && (status_o == pftbl_pkg::STATUS_EXCEEDED);
  assign fields_zero  = (remaining_o == '0) && (limit_o == '0)
                     && (window_end_o == '0) && (retry_wait_o == '0);
  assign out_payload  = {status_o, remaining_o, limit_o, window_end_o, retry_wait_o};

  // a result carries one of the three status codes
  `PFTBL_ASSERT_NOW(a_status_code, out_valid_o, status_known)

  // a reset result reports all zero fields
  `PFTBL_ASSERT_NOW(a_reset_zero, is_reset, fields_zero)

  // a refused check leaves an empty bucket
  `PFTBL_ASSERT_NOW(a_refused_empty, is_refused, remaining_o == '0)

  // a stalled item holds
  `PFTBL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_payload))

endmodule

bind per_flow_token_bucket_limiter pftbl_chk u_chk (.*);

`default_nettype wire
